FILE: rtl/assert_macros.svh
// assertion helpers shared by dnlc_queue and dnlc_back
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge outside reset
`define DNLC_ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// expression must never be true outside reset
`define DNLC_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define DNLC_ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg)
`define DNLC_ASSERT_NEVER(lbl, clk, rst_n, expr, msg)

`endif

`endif

FILE: rtl/dnlc_pkg.sv
`default_nettype none

package dnlc_pkg;

	localparam int unsigned QUEUE_DEPTH = 4;

	// character classes seen by the recognizer
	typedef enum logic [2:0] {
		CL_DIGIT = 3'd0,
		CL_SIGN  = 3'd1,
		CL_SPACE = 3'd2,
		CL_DOT   = 3'd3,
		CL_EXP   = 3'd4,
		CL_OTHER = 3'd5
	} cls_t;

	// one classified character as it sits in the queue
	typedef struct packed {
		cls_t cls;
		logic is_final;
	} item_t;

endpackage

`default_nettype wire

FILE: rtl/dnlc_front.sv
`default_nettype none

module dnlc_front (
	input  wire logic           [7:0] ch,
	input  wire logic                 is_final,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic                 q_full,
	output logic                      push,
	output dnlc_pkg::item_t           push_item
);

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2b;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_DOT   = 8'h2e;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_LOW_E = 8'h65;

	function automatic dnlc_pkg::cls_t classify(input logic [7:0] c);
		dnlc_pkg::cls_t k;
		if (c >= CH_ZERO && c <= CH_NINE) begin
			k = dnlc_pkg::CL_DIGIT;
		end else if (c == CH_PLUS || c == CH_MINUS) begin
			k = dnlc_pkg::CL_SIGN;
		end else if (c == CH_SPACE) begin
			k = dnlc_pkg::CL_SPACE;
		end else if (c == CH_DOT) begin
			k = dnlc_pkg::CL_DOT;
		end else if (c == CH_LOW_E) begin
			k = dnlc_pkg::CL_EXP;
		end else begin
			k = dnlc_pkg::CL_OTHER;
		end
		return k;
	endfunction

	assign in_stall           = q_full;
	assign push               = in_valid && !q_full;
	assign push_item.cls      = classify(ch);
	assign push_item.is_final = is_final;

endmodule

`default_nettype wire

FILE: rtl/dnlc_queue.sv
`default_nettype none
`include "assert_macros.svh"

module dnlc_queue #(
	parameter int unsigned DEPTH = dnlc_pkg::QUEUE_DEPTH
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire dnlc_pkg::item_t push_item,
	input  wire logic            pop,
	output dnlc_pkg::item_t      head_item,
	output logic                 full,
	output logic                 empty
);

	localparam int unsigned PW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);

	dnlc_pkg::item_t mem_q [DEPTH];
	logic [PW-1:0]   wr_q;
	logic [PW-1:0]   rd_q;
	logic [CW-1:0]   cnt_q;

	assign full      = (cnt_q == CW'(DEPTH));
	assign empty     = (cnt_q == '0);
	assign head_item = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	`DNLC_ASSERT_NEVER(a_cnt_bound, clk, arst_n, cnt_q > CW'(DEPTH), "queue count over depth")
	`DNLC_ASSERT_ALWAYS(a_cnt_up, clk, arst_n, (push && !pop) |=> (cnt_q == $past(cnt_q) + 1'b1), "queue count did not grow")
	`DNLC_ASSERT_ALWAYS(a_drain, clk, arst_n, (pop && !push && cnt_q == CW'(1)) |=> empty, "queue not empty after last pop")

endmodule

`default_nettype wire

FILE: rtl/dnlc_back.sv
`default_nettype none
`include "assert_macros.svh"

module dnlc_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire dnlc_pkg::item_t head_item,
	input  wire logic            q_empty,
	output logic                 pop,
	output logic                 is_number,
	output logic                 out_valid,
	input  wire logic            out_stall
);

	typedef enum logic [3:0] {
		PH_LEAD    = 4'd0,
		PH_SIGN    = 4'd1,
		PH_INT     = 4'd2,
		PH_DOTONLY = 4'd3,
		PH_FRAC    = 4'd4,
		PH_EXP     = 4'd5,
		PH_EXPSIGN = 4'd6,
		PH_EXPDIG  = 4'd7,
		PH_TRAIL   = 4'd8,
		PH_FAIL    = 4'd9
	} phase_t;

	phase_t phase_q;
	phase_t nxt;
	logic   out_valid_q;
	logic   is_number_q;
	logic   accepting;

	always_comb begin
		nxt = PH_FAIL;
		case (phase_q)
			PH_LEAD: begin
				case (head_item.cls)
					dnlc_pkg::CL_SPACE: nxt = PH_LEAD;
					dnlc_pkg::CL_SIGN:  nxt = PH_SIGN;
					dnlc_pkg::CL_DIGIT: nxt = PH_INT;
					dnlc_pkg::CL_DOT:   nxt = PH_DOTONLY;
					default:            nxt = PH_FAIL;
				endcase
			end
			PH_SIGN: begin
				case (head_item.cls)
					dnlc_pkg::CL_DIGIT: nxt = PH_INT;
					dnlc_pkg::CL_DOT:   nxt = PH_DOTONLY;
					default:            nxt = PH_FAIL;
				endcase
			end
			PH_INT: begin
				case (head_item.cls)
					dnlc_pkg::CL_DIGIT: nxt = PH_INT;
					dnlc_pkg::CL_DOT:   nxt = PH_FRAC;
					dnlc_pkg::CL_EXP:   nxt = PH_EXP;
					dnlc_pkg::CL_SPACE: nxt = PH_TRAIL;
					default:            nxt = PH_FAIL;
				endcase
			end
			PH_DOTONLY: begin
				case (head_item.cls)
					dnlc_pkg::CL_DIGIT: nxt = PH_FRAC;
					default:            nxt = PH_FAIL;
				endcase
			end
			PH_FRAC: begin
				case (head_item.cls)
					dnlc_pkg::CL_DIGIT: nxt = PH_FRAC;
					dnlc_pkg::CL_EXP:   nxt = PH_EXP;
					dnlc_pkg::CL_SPACE: nxt = PH_TRAIL;
					default:            nxt = PH_FAIL;
				endcase
			end
			PH_EXP: begin
				case (head_item.cls)
					dnlc_pkg::CL_SIGN:  nxt = PH_EXPSIGN;
					dnlc_pkg::CL_DIGIT: nxt = PH_EXPDIG;
					default:            nxt = PH_FAIL;
				endcase
			end
			PH_EXPSIGN: begin
				case (head_item.cls)
					dnlc_pkg::CL_DIGIT: nxt = PH_EXPDIG;
					default:            nxt = PH_FAIL;
				endcase
			end
			PH_EXPDIG: begin
				case (head_item.cls)
					dnlc_pkg::CL_DIGIT: nxt = PH_EXPDIG;
					dnlc_pkg::CL_SPACE: nxt = PH_TRAIL;
					default:            nxt = PH_FAIL;
				endcase
			end
			PH_TRAIL: begin
				case (head_item.cls)
					dnlc_pkg::CL_SPACE: nxt = PH_TRAIL;
					default:            nxt = PH_FAIL;
				endcase
			end
			default: nxt = PH_FAIL;
		endcase
	end

	assign accepting = (nxt == PH_INT) || (nxt == PH_FRAC) ||
		(nxt == PH_EXPDIG) || (nxt == PH_TRAIL);

	// a final character needs the output register free or draining this cycle
	assign pop = !q_empty && (!head_item.is_final || !out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_LEAD;
			out_valid_q <= 1'b0;
			is_number_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (pop) begin
				if (head_item.is_final) begin
					phase_q     <= PH_LEAD;
					out_valid_q <= 1'b1;
					is_number_q <= accepting;
				end else begin
					phase_q <= nxt;
				end
			end
		end
	end

	assign out_valid = out_valid_q;
	assign is_number = is_number_q;

	`DNLC_ASSERT_ALWAYS(a_final_done, clk, arst_n, (pop && head_item.is_final) |=> (out_valid_q && phase_q == PH_LEAD), "final character did not produce a result")

endmodule

`default_nettype wire

FILE: rtl/decimal_number_literal_checker_top.sv
// channel  | valid     | stall     | payload
// ---------+-----------+-----------+------------------
// input    | in_valid  | in_stall  | ch[7:0], is_final
// output   | out_valid | out_stall | is_number
//
// one character per cycle is accepted while the character queue has room
// a result follows its final character through the queue write, then the result register update
// reset empties the queue, clears the result register and puts the recognizer at leading spaces
// out_stall holds back only final characters; others keep draining from the queue
// in_stall rises only when all Q_DEPTH queue entries are taken
`default_nettype none

module decimal_number_literal_checker_top #(
	parameter int unsigned Q_DEPTH = dnlc_pkg::QUEUE_DEPTH
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic [7:0] ch,
	input  wire logic       is_final,
	input  wire logic       in_valid,
	output logic            in_stall,
	output logic            is_number,
	output logic            out_valid,
	input  wire logic       out_stall
);

	dnlc_pkg::item_t push_item;
	dnlc_pkg::item_t head_item;
	logic            push;
	logic            pop;
	logic            q_full;
	logic            q_empty;

	dnlc_front u_front (
		.ch        (ch),
		.is_final  (is_final),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.q_full    (q_full),
		.push      (push),
		.push_item (push_item)
	);

	dnlc_queue #(
		.DEPTH (Q_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head_item (head_item),
		.full      (q_full),
		.empty     (q_empty)
	);

	dnlc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_item (head_item),
		.q_empty   (q_empty),
		.pop       (pop),
		.is_number (is_number),
		.out_valid (out_valid),
		.out_stall (out_stall)
	);

endmodule

`default_nettype wire
